>>> rtl/sefd_pkg.sv
`default_nettype none

package sefd_pkg;

    // framing bytes
    localparam logic [7:0] STX_BYTE = 8'h5A;
    localparam logic [7:0] ETX_BYTE = 8'hA5;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // default payload buffer depth
    localparam int MAX_PAYLOAD_DEF = 64;

    // controller states
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ID,
        ST_LENH,
        ST_LENL,
        ST_DATA,
        ST_BCC,
        ST_ETX,
        ST_DRAIN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic cap_id;
        logic cap_lenh;
        logic cap_lenl;
        logic wr_data;
        logic xor_en;
        logic clr;
        logic cnt_clr;
        logic start_drain;
        logic draining;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_stx;
        logic is_etx;
        logic len_too_big;
        logic len_zero;
        logic data_last;
        logic xor_match;
        logic drain_done;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/sefd_if.sv
`default_nettype none

// received byte channel
interface sefd_in_if
    import sefd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sefd_out_if
    import sefd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] data_byte;
    logic              empty_res;
    logic              last;

    modport source (output valid, output frame_id, output payload_length,
                    output data_byte, output empty_res, output last, input ready);
    modport sink   (input valid, input frame_id, input payload_length,
                    input data_byte, input empty_res, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/sefd_ctrl.sv
`default_nettype none

module sefd_ctrl
    import sefd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   fire;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state != ST_DRAIN);
    assign fire       = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.draining = (r_state == ST_DRAIN);
        unique case (r_state)
            ST_HUNT: begin
                if (fire && i_sts.is_stx) begin
                    o_cmd.clr = 1'b1;
                    n_state   = ST_ID;
                end
            end
            ST_ID: begin
                if (fire) begin
                    o_cmd.cap_id = 1'b1;
                    o_cmd.xor_en = 1'b1;
                    n_state      = ST_LENH;
                end
            end
            ST_LENH: begin
                if (fire) begin
                    o_cmd.cap_lenh = 1'b1;
                    o_cmd.xor_en   = 1'b1;
                    n_state        = ST_LENL;
                end
            end
            ST_LENL: begin
                if (fire) begin
                    o_cmd.cap_lenl = 1'b1;
                    o_cmd.xor_en   = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    if (i_sts.len_too_big) begin
                        o_cmd.clr = 1'b1;
                        n_state   = i_sts.is_stx ? ST_ID : ST_HUNT;
                    end else if (i_sts.len_zero) begin
                        n_state = ST_BCC;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (fire) begin
                    o_cmd.wr_data = 1'b1;
                    o_cmd.xor_en  = 1'b1;
                    if (i_sts.data_last) begin
                        n_state = ST_BCC;
                    end
                end
            end
            ST_BCC: begin
                if (fire) begin
                    if (i_sts.xor_match) begin
                        n_state = ST_ETX;
                    end else begin
                        o_cmd.clr = 1'b1;
                        n_state   = i_sts.is_stx ? ST_ID : ST_HUNT;
                    end
                end
            end
            ST_ETX: begin
                if (fire) begin
                    o_cmd.clr = 1'b1;
                    if (i_sts.is_etx) begin
                        o_cmd.start_drain = 1'b1;
                        n_state           = ST_DRAIN;
                    end else begin
                        n_state = i_sts.is_stx ? ST_ID : ST_HUNT;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_sts.drain_done) begin
                    n_state = ST_HUNT;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sefd_dp.sv
`default_nettype none

module sefd_dp
    import sefd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [BYTE_W-1:0]      o_frame_id,
    output logic [LEN_W-1:0]       o_payload_length,
    output logic [BYTE_W-1:0]      o_data_byte,
    output logic                   o_empty_res,
    output logic                   o_last
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] r_id;
    logic [BYTE_W-1:0] r_len_hi;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_xor;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    logic [LEN_W-1:0]  r_rd_addr;
    logic              r_pend;
    logic [BYTE_W-1:0] r_mem_q;
    logic              r_q_last;
    logic              r_q_empty;

    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_id;
    logic [LEN_W-1:0]  r_o_len;
    logic [BYTE_W-1:0] r_o_data;
    logic              r_o_empty;
    logic              r_o_last;

    logic [LEN_W-1:0]  n_total;
    logic              issued_all;
    logic              rd_en;
    logic              load;
    logic [BYTE_W-1:0] count_inc;

    // frame header and check registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id     <= '0;
            r_len_hi <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_xor    <= '0;
        end else begin
            if (i_cmd.cap_id) begin
                r_id <= i_rx_byte;
            end
            if (i_cmd.cap_lenh) begin
                r_len_hi <= i_rx_byte;
            end
            if (i_cmd.cap_lenl) begin
                r_len <= i_rx_byte[LEN_W-1:0];
            end
            if (i_cmd.clr) begin
                r_xor <= '0;
            end else if (i_cmd.xor_en) begin
                r_xor <= r_xor ^ i_rx_byte;
            end
            if (i_cmd.clr || i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.wr_data) begin
                r_count <= r_count + LEN_W'(1);
            end
        end
    end

    // payload buffer write
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_data) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_rx_byte;
        end
    end

    // status toward the controller
    assign count_inc = {1'b0, r_count} + BYTE_W'(1);
    always_comb begin
        o_sts.is_stx      = (i_rx_byte == STX_BYTE);
        o_sts.is_etx      = (i_rx_byte == ETX_BYTE);
        o_sts.len_too_big = (r_len_hi != '0) || (i_rx_byte > BYTE_W'(MAX_PAYLOAD));
        o_sts.len_zero    = (r_len_hi == '0) && (i_rx_byte == '0);
        o_sts.data_last   = (count_inc >= {1'b0, r_len});
        o_sts.xor_match   = (i_rx_byte == r_xor);
        o_sts.drain_done  = issued_all && !r_pend;
    end

    // drain sequencing: read stage then output register
    assign n_total    = (r_len == '0) ? LEN_W'(1) : r_len;
    assign issued_all = (r_rd_addr == n_total);
    assign load       = r_pend && (!r_o_valid || i_out_ready);
    assign rd_en      = i_cmd.draining && !issued_all && (!r_pend || load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cmd.start_drain) begin
                r_rd_addr <= '0;
            end else if (rd_en) begin
                r_rd_addr <= r_rd_addr + LEN_W'(1);
            end
            if (rd_en) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
        end
    end

    // registered buffer read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q   <= r_mem[r_rd_addr[ADDR_W-1:0]];
            r_q_last  <= (r_rd_addr == n_total - LEN_W'(1));
            r_q_empty <= (r_len == '0);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_id    <= r_id;
            r_o_len   <= r_len;
            r_o_data  <= r_q_empty ? '0 : r_mem_q;
            r_o_empty <= r_q_empty;
            r_o_last  <= r_q_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_frame_id       = r_o_id;
    assign o_payload_length = r_o_len;
    assign o_data_byte      = r_o_data;
    assign o_empty_res      = r_o_empty;
    assign o_last           = r_o_last;

endmodule

`default_nettype wire

>>> rtl/stx_etx_frame_deframer_top.sv
// STX/ETX deframer with XOR block check.
// i_rx carries received bytes (valid/ready); o_res carries one request per
// payload byte: frame id, payload length, data byte, empty flag, last flag.
// Frames are STX 0x5A, id, length high, length low, payload, BCC, ETX 0xA5.
// Outside a drain i_rx takes one byte per cycle. After a correct ETX
// the input stalls while the payload drains from the buffer: each
// result passes the buffer read stage and then the output register,
// one result per cycle while o_res is ready, and i_rx is held off until
// the drain ends (an empty frame gives one result marked empty and last).
// The drain rate is set by the single read port of the payload buffer.
// A bad check byte, missing ETX or oversized length drops the frame with
// no result; a dropping byte of 0x5A opens a new frame.
// When o_res stalls the result holds in the output register and the drain
// waits; bytes are taken again once the last result has left the read stage.
// Synchronous reset returns to hunting for STX and empties the output.
`default_nettype none

module stx_etx_frame_deframer_top
    import sefd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    sefd_in_if.sink    i_rx,
    sefd_out_if.source o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    sefd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // buffer, check and output
    sefd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx.rx_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_frame_id       (o_res.frame_id),
        .o_payload_length (o_res.payload_length),
        .o_data_byte      (o_res.data_byte),
        .o_empty_res      (o_res.empty_res),
        .o_last           (o_res.last)
    );

`ifndef SYNTH
    // no byte taken while a payload drains
    a_no_rx_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.draining |-> !i_rx.ready)
        else $error("byte request accepted during drain");

    // an empty frame result closes its run
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.empty_res) |-> o_res.last)
        else $error("empty result not marked last");

    // a non-final result means the drain is still running
    a_mid_run_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.last) |-> cmd.draining)
        else $error("mid-run result outside drain");

    // a drain start leads into the drain with i_rx held off
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_drain |=> (cmd.draining && !i_rx.ready))
        else $error("drain did not start after ETX");
`endif

endmodule

`default_nettype wire
